>>> rtl/frhf_pkg.sv
// frhf_pkg: types and constants shared by the frame receiver modules
// holds the phase enum, result kind codes and the result record type
// no dependencies
`default_nettype none

package frhf_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hAA;
    localparam logic [7:0] FTR_BYTE = 8'h55;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_OP   = 3'd1,
        PH_LEN  = 3'd2,
        PH_PAY  = 3'd3,
        PH_FTR  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] frame_op;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/frhf_decode.sv
// frhf_decode: frame parser state and per-byte result decode
// one byte per cycle while fire is high; depends on frhf_pkg
`default_nettype none

module frhf_decode (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       byte_in,
    output logic                  res_vld,
    output frhf_pkg::result_t     res
);
    import frhf_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_op_reg, held_op_next;
    logic [7:0] frame_len_reg, frame_len_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            held_op_reg   <= 8'd0;
            frame_len_reg <= 8'd0;
            count_reg     <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            held_op_reg   <= held_op_next;
            frame_len_reg <= frame_len_next;
            count_reg     <= count_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        held_op_next   = held_op_reg;
        frame_len_next = frame_len_reg;
        count_next     = count_reg;
        res_vld        = 1'b0;
        res.kind       = KIND_DATA;
        res.frame_op   = held_op_reg;
        res.data_byte  = 8'd0;
        res.byte_index = 8'd0;
        if (fire)
        begin
            case (phase_reg)
                PH_OP:
                begin
                    held_op_next = byte_in;
                    phase_next   = PH_LEN;
                end
                PH_LEN:
                begin
                    frame_len_next = byte_in;
                    count_next     = 8'd0;
                    phase_next     = (byte_in == 8'd0) ? PH_FTR : PH_PAY;
                end
                PH_PAY:
                begin
                    res_vld        = 1'b1;
                    res.kind       = KIND_DATA;
                    res.data_byte  = byte_in;
                    res.byte_index = count_reg;
                    count_next     = count_inc;
                    if (count_inc == frame_len_reg)
                    begin
                        phase_next = PH_FTR;
                    end
                end
                PH_FTR:
                begin
                    res_vld        = 1'b1;
                    res.kind       = (byte_in == FTR_BYTE) ? KIND_OK : KIND_BAD;
                    res.byte_index = frame_len_reg;
                    phase_next     = PH_HUNT;
                end
                default:
                begin
                    // unused codes behave as hunting
                    phase_next = (byte_in == HDR_BYTE) ? PH_OP : PH_HUNT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/frhf_out_buf.sv
// frhf_out_buf: two-entry result buffer between decode and the result channel
// its ready depends only on its own fill, never on the downstream ready
// depends on frhf_pkg
`default_nettype none

module frhf_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire frhf_pkg::result_t wr_data,
    output logic                   not_full,
    output logic                   rd_vld,
    input  wire logic              rd_rdy,
    output frhf_pkg::result_t      rd_data
);
    import frhf_pkg::*;

    result_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign not_full = (count_reg != 2'd2);
    assign rd_vld   = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && not_full;
    assign do_rd    = rd_vld && rd_rdy;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/frame_receiver_header_footer_check_core.sv
// frame_receiver_header_footer_check_core: streaming deframer top level
// instantiates frhf_decode and frhf_out_buf; depends on frhf_pkg
//
// usage:
//   rx channel (rx_valid/rx_ready/rx_byte) carries one received byte per transfer
//   res channel (res_valid/res_ready) carries one result per transfer:
//     kind 0 payload byte with byte_index = position, data_byte = byte
//     kind 1/2 frame end (footer ok/bad) with byte_index = frame length
//   frames look like 0xAA, opcode, length, payload bytes, 0x55
//   header, opcode and length bytes and bytes seen while hunting give no result
//   downstream drops the payload of any frame ending with kind 2
// timing:
//   one byte accepted per cycle while the result buffer has room; a result
//   shows on res_valid once its byte has passed the input register and been
//   decoded into the two-entry result buffer, and then waits there for res_ready
//   the parser state advances once per byte as it leaves the input register
// stall:
//   rx_ready stays high while the result buffer has room, so bytes keep flowing
//   while one result waits; with res_ready low the buffer fills and rx_ready
//   drops until a result transfer frees a slot
// reset:
//   rst_n clears the input register, the result buffer and the parser, which
//   starts out hunting for the header byte
`default_nettype none

module frame_receiver_header_footer_check_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [1:0]      kind,
    output logic [7:0]      frame_op,
    output logic [7:0]      data_byte,
    output logic [7:0]      byte_index
);
    import frhf_pkg::*;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;

    logic       buf_not_full;
    logic       advance;
    logic       dec_vld;
    result_t    dec_res;
    result_t    out_res;

    // a byte leaves the input register when the buffer can take its result
    assign advance  = in_vld_reg && buf_not_full;
    assign rx_ready = !in_vld_reg || buf_not_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            in_vld_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // parser: state update and result decode for the registered byte
    frhf_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .byte_in (in_byte_reg),
        .res_vld (dec_vld),
        .res     (dec_res)
    );

    // result register plus skid slot
    frhf_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (dec_vld),
        .wr_data  (dec_res),
        .not_full (buf_not_full),
        .rd_vld   (res_valid),
        .rd_rdy   (res_ready),
        .rd_data  (out_res)
    );

    assign kind       = out_res.kind;
    assign frame_op   = out_res.frame_op;
    assign data_byte  = out_res.data_byte;
    assign byte_index = out_res.byte_index;

endmodule

`default_nettype wire

>>> tb/sv/frame_receiver_header_footer_check_core_tb.sv
// testbench for frame_receiver_header_footer_check_core: directed frames, then random streams
// keeps its own deframer state to predict every payload and frame end transfer
// depends on frhf_pkg and the rtl top level
`default_nettype none

module frame_receiver_header_footer_check_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import frhf_pkg::*;

    // random part length, the drain wait limit and the settle tail
    localparam int RANDOM_ITEMS  = 550;
    localparam int DRAIN_CYCLES  = 4000;
    localparam int TAIL_CYCLES   = 6;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] frame_op;
    logic [7:0] data_byte;
    logic [7:0] byte_index;

    // predicted results in transfer order
    result_t pending_results[$];

    // deframer state as predicted from the accepted bytes
    phase_t     model_phase = PH_HUNT;
    logic [7:0] model_op    = 8'h00;
    logic [7:0] model_len   = 8'h00;
    logic [7:0] model_count = 8'h00;

    int  error_count   = 0;
    int  bytes_counted = 0;
    int  stall_left    = 0;
    bit  src_idle_on   = 1'b1;
    bit  sink_idle_on  = 1'b1;

    frame_receiver_header_footer_check_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .kind       (kind),
        .frame_op   (frame_op),
        .data_byte  (data_byte),
        .byte_index (byte_index)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit, well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("frame_receiver_header_footer_check_core_tb failed");
        $finish;
    end

    // one line per problem, counted
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // advance the predicted deframer by one accepted byte; returns 1 when a
    // result transfer is due for this byte
    function automatic bit deframe_step(input logic [7:0] b, output result_t res);
        bit produced;
        produced = 1'b0;
        res = '0;
        case (model_phase)
            PH_OP:
            begin
                model_op    = b;
                model_phase = PH_LEN;
            end
            PH_LEN:
            begin
                // zero length goes straight to the footer check
                model_len   = b;
                model_count = 8'h00;
                model_phase = (b == 8'h00) ? PH_FTR : PH_PAY;
            end
            PH_PAY:
            begin
                res.kind       = KIND_DATA;
                res.frame_op   = model_op;
                res.data_byte  = b;
                res.byte_index = model_count;
                produced       = 1'b1;
                model_count    = model_count + 8'h01;
                if (model_count == model_len)
                    model_phase = PH_FTR;
            end
            PH_FTR:
            begin
                // a bad footer byte is never looked at as a header
                res.kind       = (b == FTR_BYTE) ? KIND_OK : KIND_BAD;
                res.frame_op   = model_op;
                res.data_byte  = 8'h00;
                res.byte_index = model_len;
                produced       = 1'b1;
                model_phase    = PH_HUNT;
            end
            default:
            begin
                // hunting: only the header byte moves on
                model_phase = (b == HDR_BYTE) ? PH_OP : PH_HUNT;
            end
        endcase
        return produced;
    endfunction

    // one byte transfer on the rx channel, with an optional idle burst first;
    // valid stays high between back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        result_t res;
        bit      counts;
        if (src_idle_on && $urandom_range(0, 7) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        // wait for the transfer edge; values read here are the pre-edge ones
        do
            @(posedge clk);
        while (!rx_ready);
        // bytes dropped while hunting do not count as stimulus
        counts = !(model_phase == PH_HUNT && b != HDR_BYTE);
        if (counts)
            bytes_counted++;
        if (deframe_step(b, res))
            pending_results = {pending_results, res};
    endtask

    // full frame with random payload
    task automatic send_frame(input logic [7:0] op, input logic [7:0] len,
                              input logic [7:0] footer);
        send_byte(HDR_BYTE);
        send_byte(op);
        send_byte(len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(footer);
    endtask

    // hold the sender off until every predicted result has gone out
    task automatic pause_until_drained();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // random stall bursts on the result side
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            res_ready  <= 1'b0;
        end
        else if (sink_idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            res_ready  <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    // result checker: each transfer against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("unexpected result kind %0d op %0h data %0h index %0d",
                                       kind, frame_op, data_byte, byte_index));
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                    report_error($sformatf("kind: expected %0d got %0d", want.kind, kind));
                if (frame_op !== want.frame_op)
                    report_error($sformatf("frame_op: expected %0h got %0h",
                                           want.frame_op, frame_op));
                if (data_byte !== want.data_byte)
                    report_error($sformatf("data_byte: expected %0h got %0h",
                                           want.data_byte, data_byte));
                if (byte_index !== want.byte_index)
                    report_error($sformatf("byte_index: expected %0d got %0d",
                                           want.byte_index, byte_index));
            end
        end
    end

    // bytes seen while hunting, including a stray footer byte
    task automatic test_hunt_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(FTR_BYTE);
    endtask

    // zero length frame with extreme opcode, good footer
    task automatic test_zero_length();
        send_byte(HDR_BYTE);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(FTR_BYTE);
    endtask

    // four payload bytes, extreme values, header and footer codes inside payload
    task automatic test_payload_extremes();
        send_byte(HDR_BYTE);
        send_byte(8'h00);
        send_byte(8'h04);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(HDR_BYTE);
        send_byte(FTR_BYTE);
        send_byte(FTR_BYTE);
    endtask

    // bad footer that is the header byte, then a byte that must be dropped;
    // a header right after a header is taken as the opcode
    task automatic test_bad_footer();
        send_byte(HDR_BYTE);
        send_byte(8'h5A);
        send_byte(8'h01);
        send_byte(8'h33);
        send_byte(HDR_BYTE);
        send_byte(8'h01);
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // longest frame reaches byte index 255
    task automatic test_long_frames();
        send_frame(8'($urandom_range(0, 255)), 8'hFF, FTR_BYTE);
        send_frame(8'($urandom_range(0, 255)), 8'h80, 8'($urandom_range(0, 255)));
    endtask

    // mostly well formed frames with random content, some noise and broken frames
    task automatic test_random_stream();
        int          start;
        int          pick;
        int          len;
        int          cut;
        bit          drained;
        logic [7:0]  footer;
        start   = bytes_counted;
        drained = 1'b0;
        while (bytes_counted < start + RANDOM_ITEMS)
        begin
            // idle stretches come and go per frame
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(0, 12);
                footer = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : FTR_BYTE;
                send_frame(8'($urandom_range(0, 255)), 8'(len), footer);
            end
            else if (pick < 90)
            begin
                // noise, biased toward the framing codes
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 2))
                        0:       send_byte(HDR_BYTE);
                        1:       send_byte(FTR_BYTE);
                        default: send_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            else
            begin
                // frame cut short; the next bytes are taken as its payload
                len = $urandom_range(1, 12);
                cut = $urandom_range(0, len - 1);
                send_byte(HDR_BYTE);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'(len));
                for (int i = 0; i < cut; i++)
                    send_byte(8'($urandom_range(0, 255)));
            end
            // hold off once in the middle until everything has come out
            if (!drained && bytes_counted > start + RANDOM_ITEMS / 2)
            begin
                pause_until_drained();
                drained = 1'b1;
            end
        end
    endtask

    // no idling on either side: full rate both ways
    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (30)
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)),
                       ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : FTR_BYTE);
    endtask

    initial
    begin
        int waited;
        // reset held from the start, released on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hunt_noise();
        test_zero_length();
        test_payload_extremes();
        test_bad_footer();
        test_long_frames();
        test_random_stream();
        test_back_to_back();

        // drain: wait for every prediction, then let the pipeline settle
        rx_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));

        if (error_count == 0)
            $display("frame_receiver_header_footer_check_core_tb passed");
        else
            $display("frame_receiver_header_footer_check_core_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
